### src/rufp_pkg.sv
`default_nettype none
package rufp_pkg;

  // Frame markers, oldest byte in the high bits.
  localparam logic [31:0] HDR_REPORT = 32'hF4F3F2F1;
  localparam logic [31:0] HDR_CMD    = 32'hFDFCFBFA;
  localparam logic [31:0] FTR_REPORT = 32'hF8F7F6F5;
  localparam logic [31:0] FTR_CMD    = 32'h04030201;
  localparam logic [7:0]  MARK_HEAD  = 8'hAA;
  localparam logic [7:0]  MARK_TAIL  = 8'h55;
  localparam logic [7:0]  ENG_MODE   = 8'h01;
  localparam logic [15:0] CMD_OFFSET = 16'h0100;
  localparam int          MAX_RESULTS = 64;

  // Result kinds.
  localparam logic [2:0] KIND_BASIC  = 3'd0;
  localparam logic [2:0] KIND_ENG    = 3'd1;
  localparam logic [2:0] KIND_MOVING = 3'd2;
  localparam logic [2:0] KIND_STILL  = 3'd3;
  localparam logic [2:0] KIND_ACK    = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_SRCH, S_SRCH_D, S_HDR, S_L0, S_L1, S_FTR, S_FTR_D,
    S_PAY, S_PAY_D, S_T0, S_T0_D, S_T1_D, S_EREC, S_GATE, S_GATE_D,
    S_EACK, S_DONE, S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  target_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_energy;
    logic [15:0] still_distance;
    logic [7:0]  still_energy;
    logic [15:0] detect_distance;
    logic [3:0]  gate_index;
    logic [7:0]  gate_energy;
    logic [15:0] ack_command;
    logic [15:0] ack_status;
  } result_t;

  // Footer byte at position j of a report or command frame.
  function automatic logic [7:0] ftr_byte(input logic report, input logic [1:0] j);
    logic [31:0] f;
    f = report ? FTR_REPORT : FTR_CMD;
    return f[8*(3-j) +: 8];
  endfunction

endpackage
`default_nettype wire

### src/rufp_ram.sv
`default_nettype none
module rufp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/rufp_out.sv
`default_nettype none
module rufp_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              emit,
  input  wire rufp_pkg::result_t res,
  input  wire logic              flush,
  input  wire logic              ready,
  output logic                   valid,
  output rufp_pkg::result_t      out_res,
  output logic                   out_last,
  output logic                   pend_valid
);

  rufp_pkg::result_t pend;

  // A result is held back one place so that the final one of an item can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      pend_valid <= 1'b0;
    end else if (emit) begin
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
        valid    <= 1'b1;
      end else if (ready) begin
        valid <= 1'b0;
      end
      pend       <= res;
      pend_valid <= 1'b1;
    end else if (flush) begin
      out_res    <= pend;
      out_last   <= 1'b1;
      valid      <= 1'b1;
      pend_valid <= 1'b0;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### src/radar_uart_frame_parser.sv
`default_nettype none
// Operation: a byte is taken only in the idle state; the store is then searched for a header,
// and every complete frame in it is parsed, with up to MAX_RESULTS results emitted, before the
// next byte is taken. A resynchronisation rescans the store byte by byte through the single read port.
// Reset: rst (synchronous) empties the store and clears the output; RAM contents are kept.
module radar_uart_frame_parser #(
  parameter int MAX_PAYLOAD    = 128,
  parameter int MAX_GATE_INDEX = 8,
  parameter int BUFFER_BYTES   = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // rx_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata,   // target_state, moving_distance, moving_energy,
                                       // still_distance, still_energy, detect_distance,
                                       // gate_index, gate_energy, ack_command, ack_status
  output logic [2:0]        m_tuser,   // kind
  output logic              m_tlast    // last
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);

  rufp_pkg::state_t  state, state_next;
  rufp_pkg::result_t res, out_res;

  logic [AW-1:0] head, off_c, drop_n, raddr, waddr;
  logic [FW-1:0] fill, k;
  logic [31:0]   win, w_c;
  logic          report, tail_ok, phase, eng;
  logic [15:0]   len, len_c;
  logic [3:0]    j, lim_m, lim_s, lim;
  logic [7:0]    p [13];
  logic [4:0]    g;
  logic [7:0]    idx, rdata;
  logic [6:0]    cnt;
  logic          do_drop, clr, emit, emit_go, flush, stall, out_free, pend_valid, out_last;
  logic          hit_r, hit_c, accept;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(BUFFER_BYTES)) begin
      s = s - (AW+1)'(BUFFER_BYTES);
    end
    return s[AW-1:0];
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign stall    = pend_valid && !out_free && (cnt < 7'(rufp_pkg::MAX_RESULTS));
  assign emit_go  = emit && (cnt < 7'(rufp_pkg::MAX_RESULTS));
  assign w_c      = {win[23:0], rdata};
  assign hit_r    = (k >= FW'(3)) && (w_c == rufp_pkg::HDR_REPORT);
  assign hit_c    = (k >= FW'(3)) && (w_c == rufp_pkg::HDR_CMD);
  assign len_c    = {rdata, len[7:0]};
  assign eng      = (p[0] == rufp_pkg::ENG_MODE);
  assign lim      = phase ? lim_s : lim_m;
  assign raddr    = wrap(head, off_c);
  assign waddr    = (fill == FW'(BUFFER_BYTES)) ? head : wrap(head, fill[AW-1:0]);

  rufp_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rufp_out u_out (
    .clk        (clk),
    .rst        (rst),
    .emit       (emit_go),
    .res        (res),
    .flush      (flush),
    .ready      (m_tready),
    .valid      (m_tvalid),
    .out_res    (out_res),
    .out_last   (out_last),
    .pend_valid (pend_valid)
  );

  assign m_tuser = out_res.kind;
  assign m_tlast = out_last;
  assign m_tdata = {4'd0, out_res.ack_status, out_res.ack_command, out_res.gate_energy,
                    out_res.gate_index, out_res.detect_distance, out_res.still_energy,
                    out_res.still_distance, out_res.moving_energy, out_res.moving_distance,
                    out_res.target_state};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rufp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, read offset and store updates.
  always_comb begin
    state_next = state;
    off_c      = '0;
    do_drop    = 1'b0;
    drop_n     = '0;
    clr        = 1'b0;
    emit       = 1'b0;
    flush      = 1'b0;
    res        = '0;
    s_tready   = 1'b0;
    unique case (state)
      rufp_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = rufp_pkg::S_SCAN;
      end
      rufp_pkg::S_SCAN: begin
        state_next = (fill < FW'(10)) ? rufp_pkg::S_FIN : rufp_pkg::S_SRCH;
      end
      rufp_pkg::S_SRCH: begin
        off_c      = k[AW-1:0];
        state_next = rufp_pkg::S_SRCH_D;
      end
      rufp_pkg::S_SRCH_D: begin
        if (hit_r || hit_c) begin
          do_drop    = 1'b1;
          drop_n     = AW'(k - FW'(3));
          state_next = rufp_pkg::S_HDR;
        end else if (k + FW'(1) >= fill) begin
          clr        = 1'b1;
          state_next = rufp_pkg::S_FIN;
        end else begin
          state_next = rufp_pkg::S_SRCH;
        end
      end
      rufp_pkg::S_HDR: begin
        off_c = AW'(4);
        state_next = (fill < FW'(6)) ? rufp_pkg::S_FIN : rufp_pkg::S_L0;
      end
      rufp_pkg::S_L0: begin
        off_c      = AW'(5);
        state_next = rufp_pkg::S_L1;
      end
      rufp_pkg::S_L1: begin
        if (len_c > 16'(MAX_PAYLOAD)) begin
          do_drop    = 1'b1;
          drop_n     = AW'(1);
          state_next = rufp_pkg::S_SCAN;
        end else if (17'(fill) < {1'b0, len_c} + 17'd10) begin
          state_next = rufp_pkg::S_FIN;
        end else begin
          state_next = rufp_pkg::S_FTR;
        end
      end
      rufp_pkg::S_FTR: begin
        off_c      = AW'(len + 16'd6 + 16'(j));
        state_next = rufp_pkg::S_FTR_D;
      end
      rufp_pkg::S_FTR_D: begin
        if (rdata != rufp_pkg::ftr_byte(report, j[1:0])) begin
          do_drop    = 1'b1;
          drop_n     = AW'(1);
          state_next = rufp_pkg::S_SCAN;
        end else if (j == 4'd3) begin
          if (report ? (len < 16'd13) : (len < 16'd4)) state_next = rufp_pkg::S_DONE;
          else state_next = rufp_pkg::S_PAY;
        end else begin
          state_next = rufp_pkg::S_FTR;
        end
      end
      rufp_pkg::S_PAY: begin
        off_c      = AW'(16'd6 + 16'(j));
        state_next = rufp_pkg::S_PAY_D;
      end
      rufp_pkg::S_PAY_D: begin
        if (j == (report ? 4'd12 : 4'd3)) begin
          state_next = report ? rufp_pkg::S_T0 : rufp_pkg::S_EACK;
        end else begin
          state_next = rufp_pkg::S_PAY;
        end
      end
      rufp_pkg::S_T0: begin
        off_c      = AW'(len + 16'd4);
        state_next = rufp_pkg::S_T0_D;
      end
      rufp_pkg::S_T0_D: begin
        off_c      = AW'(len + 16'd5);
        state_next = rufp_pkg::S_T1_D;
      end
      rufp_pkg::S_T1_D: begin
        if (tail_ok && rdata == 8'h00 && p[1] == rufp_pkg::MARK_HEAD) begin
          state_next = rufp_pkg::S_EREC;
        end else begin
          state_next = rufp_pkg::S_DONE;
        end
      end
      rufp_pkg::S_EREC: begin
        res.kind            = eng ? rufp_pkg::KIND_ENG : rufp_pkg::KIND_BASIC;
        res.target_state    = p[2];
        res.moving_distance = {p[4], p[3]};
        res.moving_energy   = p[5];
        res.still_distance  = {p[7], p[6]};
        res.still_energy    = p[8];
        res.detect_distance = {p[10], p[9]};
        if (!stall) begin
          emit = 1'b1;
          state_next = (eng && len >= 16'd15) ? rufp_pkg::S_GATE : rufp_pkg::S_DONE;
        end
      end
      rufp_pkg::S_GATE: begin
        if (g <= {1'b0, lim} && 16'(idx) < len) begin
          off_c      = AW'(16'd6 + 16'(idx));
          state_next = rufp_pkg::S_GATE_D;
        end else if (phase) begin
          state_next = rufp_pkg::S_DONE;
        end
      end
      rufp_pkg::S_GATE_D: begin
        off_c           = AW'(16'd6 + 16'(idx));
        res.kind        = phase ? rufp_pkg::KIND_STILL : rufp_pkg::KIND_MOVING;
        res.gate_index  = g[3:0];
        res.gate_energy = rdata;
        if (!stall) begin
          emit       = 1'b1;
          state_next = rufp_pkg::S_GATE;
        end
      end
      rufp_pkg::S_EACK: begin
        res.kind        = rufp_pkg::KIND_ACK;
        res.ack_command = ({p[1], p[0]} >= rufp_pkg::CMD_OFFSET) ?
                          {p[1], p[0]} - rufp_pkg::CMD_OFFSET : {p[1], p[0]};
        res.ack_status  = {p[3], p[2]};
        if (!stall) begin
          emit       = 1'b1;
          state_next = rufp_pkg::S_DONE;
        end
      end
      rufp_pkg::S_DONE: begin
        do_drop    = 1'b1;
        drop_n     = AW'(len + 16'd10);
        state_next = rufp_pkg::S_SCAN;
      end
      rufp_pkg::S_FIN: begin
        if (!(pend_valid && !out_free)) begin
          flush      = pend_valid;
          state_next = rufp_pkg::S_IDLE;
        end
      end
      default: state_next = rufp_pkg::S_IDLE;
    endcase
  end

  // Store pointers and result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        if (fill == FW'(BUFFER_BYTES)) begin
          head <= wrap(head, AW'(1));
        end else begin
          fill <= fill + FW'(1);
        end
      end else if (clr) begin
        fill <= '0;
      end else if (do_drop) begin
        head <= wrap(head, drop_n);
        fill <= fill - FW'(drop_n);
      end
      if (state == rufp_pkg::S_FIN && state_next == rufp_pkg::S_IDLE) begin
        cnt <= '0;
      end else if (emit_go) begin
        cnt <= cnt + 7'd1;
      end
    end
  end

  // Frame working registers.
  always_ff @(posedge clk) begin
    unique case (state)
      rufp_pkg::S_SCAN: k <= '0;
      rufp_pkg::S_SRCH_D: begin
        win    <= w_c;
        report <= hit_r;
        k      <= k + FW'(1);
      end
      rufp_pkg::S_L0: len[7:0] <= rdata;
      rufp_pkg::S_L1: begin
        len[15:8] <= rdata;
        j         <= '0;
      end
      rufp_pkg::S_FTR_D: j <= (j == 4'd3) ? 4'd0 : j + 4'd1;
      rufp_pkg::S_PAY_D: begin
        p[j] <= rdata;
        j    <= j + 4'd1;
      end
      rufp_pkg::S_T0_D: tail_ok <= (rdata == rufp_pkg::MARK_TAIL);
      rufp_pkg::S_EREC: begin
        g     <= '0;
        idx   <= 8'd13;
        phase <= 1'b0;
        lim_m <= (p[11] > 8'(MAX_GATE_INDEX)) ? 4'(MAX_GATE_INDEX) : p[11][3:0];
        lim_s <= (p[12] > 8'(MAX_GATE_INDEX)) ? 4'(MAX_GATE_INDEX) : p[12][3:0];
      end
      rufp_pkg::S_GATE: begin
        if (state_next == rufp_pkg::S_GATE) begin
          phase <= 1'b1;
          g     <= '0;
        end
      end
      rufp_pkg::S_GATE_D: begin
        if (state_next == rufp_pkg::S_GATE) begin
          g   <= g + 5'd1;
          idx <= idx + 8'd1;
        end
      end
      default: ;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(BUFFER_BYTES)) else $error("store fill beyond capacity");
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < (AW+1)'(BUFFER_BYTES)) else $error("head pointer out of range");
  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == rufp_pkg::S_IDLE) |-> !pend_valid) else $error("held result not flushed");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 7'(rufp_pkg::MAX_RESULTS)) else $error("result count overrun");

endmodule
`default_nettype wire
